// ===== design/dttmu_pkg.sv =====
`timescale 1ns / 1ps

package dttmu_pkg;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_DOT  = 8'h2E;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WHOLE = 2'd1,
      PH_FRAC  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_END  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // Powers of ten up to 10^9, enough for any supported fraction length.
   function automatic logic [63:0] pow10_f(input logic [3:0] n);
      logic [63:0] p;
      unique case (n)
         4'd0: p = 64'd1;
         4'd1: p = 64'd10;
         4'd2: p = 64'd100;
         4'd3: p = 64'd1000;
         4'd4: p = 64'd10000;
         4'd5: p = 64'd100000;
         4'd6: p = 64'd1000000;
         4'd7: p = 64'd10000000;
         4'd8: p = 64'd100000000;
         4'd9: p = 64'd1000000000;
         default: p = 64'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== design/dttmu_if.sv =====
`timescale 1ns / 1ps

interface dttmu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       start_req;
   logic [7:0] end_char;

   modport source (output valid, output char_code, output start_req, output end_char,
                   input ready);
   modport sink   (input valid, input char_code, input start_req, input end_char,
                   output ready);
endinterface

interface dttmu_rsp_if import dttmu_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [63:0] value_micro;
   status_type  status;

   modport source (output valid, output value_micro, output status, input ready);
   modport sink   (input valid, input value_micro, input status, output ready);
endinterface

// ===== design/decimal_text_to_micro_units_core.sv =====
`timescale 1ns / 1ps

// Decimal text parser: takes one ASCII character per word and, on the first
// character that ends the number, returns the value in units of
// 10^-FRACTION_DIGITS with a status (ok, wrong terminator, overflow).
// Throughput is one character per cycle, except while a terminating character
// waits for a full result register to be taken. The result register loads
// when the terminating character leaves the input register, and the word is
// offered from that register. The scaled integer accumulator keeps the
// integer part already multiplied by 10^FRACTION_DIGITS and updates it with
// one shift-add by ten per digit, so no wide multiply is needed at the end. A
// finished result waiting on rsp_bus does not block input unless the next
// character would also end a number.
module decimal_text_to_micro_units_core
   import dttmu_pkg::*;
#(
   parameter int unsigned FRACTION_DIGITS = 6
) (
   input  logic            clock,
   input  logic            reset,
   dttmu_req_if.sink       req_bus,
   dttmu_rsp_if.source     rsp_bus
);

   localparam logic [63:0] SCALE  = pow10_f(4'(FRACTION_DIGITS));
   localparam int unsigned FRAC_W = $clog2(SCALE);
   localparam int unsigned CNT_W  = $clog2(FRACTION_DIGITS + 1);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        in_start_ff;
   logic [7:0]  in_end_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [63:0]        scaled_ff, scaled_in;   // integer part * SCALE, mod 2^64
   logic               ovf_ff, ovf_in;         // exact integer part * SCALE >= 2^64
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // result register
   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic               produce;
   logic               advance;
   logic               is_digit;
   logic [3:0]         digit;
   phase_type          phase_eff;
   logic [63:0]        scaled_eff;
   logic               ovf_eff;
   logic [FRAC_W-1:0]  frac_eff;
   logic [CNT_W-1:0]   count_eff;
   logic [67:0]        scaled_step;
   logic [FRAC_W+3:0]  frac_prod;
   logic [63:0]        weight;
   logic [64:0]        final_sum;

   always_comb begin
      is_digit   = (in_char_ff >= CH_ZERO) && (in_char_ff <= CH_NINE);
      digit      = is_digit ? 4'(in_char_ff - CH_ZERO) : 4'd0;

      phase_eff  = in_start_ff ? PH_WHOLE : phase_ff;
      scaled_eff = in_start_ff ? 64'd0 : scaled_ff;
      ovf_eff    = in_start_ff ? 1'b0 : ovf_ff;
      frac_eff   = in_start_ff ? '0 : frac_ff;
      count_eff  = in_start_ff ? '0 : count_ff;

      // x10 as x8 + x2, plus the digit at the scaled position
      scaled_step = {1'b0, scaled_eff, 3'b000} + {3'b000, scaled_eff, 1'b0}
                  + (68'(digit) * 68'(SCALE));
      weight      = pow10_f(4'(FRACTION_DIGITS - 1) - 4'(count_eff));
      frac_prod   = (FRAC_W + 4)'(digit) * (FRAC_W + 4)'(weight[FRAC_W-1:0]);
      final_sum   = {1'b0, scaled_eff} + 65'(frac_eff);

      phase_in      = phase_eff;
      scaled_in     = scaled_eff;
      ovf_in        = ovf_eff;
      frac_in       = frac_eff;
      count_in      = count_eff;
      produce       = 1'b0;
      rsp_value_in  = final_sum[63:0];
      rsp_status_in = (ovf_eff || final_sum[64]) ? ST_OVERFLOW : ST_OK;
      if (in_char_ff != in_end_ff) begin
         rsp_value_in  = 64'd0;
         rsp_status_in = ST_BAD_END;
      end

      unique case (phase_eff)
         PH_WHOLE: begin
            if (is_digit) begin
               scaled_in = scaled_step[63:0];
               ovf_in    = ovf_eff || (|scaled_step[67:64]);
            end else if (in_char_ff == CH_DOT) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_IDLE;
               produce  = 1'b1;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               if (32'(count_eff) < FRACTION_DIGITS) begin
                  frac_in  = frac_eff + frac_prod[FRAC_W-1:0];
                  count_in = count_eff + CNT_W'(1);
               end
            end else begin
               phase_in = PH_IDLE;
               produce  = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign advance       = in_valid_ff && (!produce || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready) begin
         in_char_ff  <= req_bus.char_code;
         in_start_ff <= req_bus.start_req;
         in_end_ff   <= req_bus.end_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         scaled_ff <= 64'd0;
         ovf_ff    <= 1'b0;
         frac_ff   <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         scaled_ff <= scaled_in;
         ovf_ff    <= ovf_in;
         frac_ff   <= frac_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && produce) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.value_micro = rsp_value_ff;
   assign rsp_bus.status      = rsp_status_ff;

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (phase_ff == PH_IDLE) && !in_valid_ff && !rsp_valid_ff)
      else $error("state not idle after reset");

   a_bad_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_BAD_END) |-> rsp_value_ff == 64'd0)
      else $error("wrong terminator word carries a value");

   a_frac_bounds: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= FRACTION_DIGITS) && (64'(frac_ff) < SCALE))
      else $error("fraction accumulator out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && produce && rsp_valid_ff && !rsp_bus.ready
      |=> in_valid_ff && $stable(phase_ff) && $stable(scaled_ff))
      else $error("terminator consumed while result register full");

endmodule

// ===== tb/decimal_text_to_micro_units_core_tb.sv =====
`timescale 1ns / 1ps

module decimal_text_to_micro_units_core_tb
   import dttmu_pkg::*;
();

   localparam int FRACTION_DIGITS = 6;
   localparam int RANDOM_CHARS    = 500;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct {
      logic [7:0] char_code;
      logic       start_req;
      logic [7:0] end_char;
   } text_char_type;

   typedef struct {
      logic [63:0] value_micro;
      status_type  status;
   } parsed_value_type;

   logic clock;
   logic reset;

   dttmu_req_if req_bus ();
   dttmu_rsp_if rsp_bus ();

   decimal_text_to_micro_units_core #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   text_char_type    char_queue[$];
   parsed_value_type expected_values[$];

   // parser shadow state
   phase_type   parse_phase;
   logic [63:0] whole_sum;
   logic [19:0] frac_sum;
   int          frac_taken;
   logic        whole_overflow;

   int chars_accepted;
   int results_seen;
   int mismatch_count;
   int numbers_ok;
   int numbers_bad_end;
   int numbers_overflow;
   int req_gap;
   int rsp_stall;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [63:0] ten_to(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) p = p * 64'd10;
      return p;
   endfunction

   // stretches of no idling, heavy idling, and light idling
   function automatic int draw_wait(input int n);
      case ((n / 40) % 3)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   function automatic logic [7:0] rand_other(input bit allow_dot);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (is_digit(b) || (!allow_dot && b == CH_DOT));
      return b;
   endfunction

   task automatic close_number(input logic [7:0] ch, input logic [7:0] endc);
      parsed_value_type r;
      logic [127:0]     wide;
      parse_phase = PH_IDLE;
      if (ch != endc) begin
         r.value_micro = 64'd0;
         r.status      = ST_BAD_END;
      end else begin
         wide = {64'd0, whole_sum} * ten_to(FRACTION_DIGITS) + {108'd0, frac_sum};
         r.value_micro = wide[63:0];
         r.status      = (whole_overflow || wide[127:64] != 64'd0) ? ST_OVERFLOW : ST_OK;
      end
      expected_values.push_back(r);
   endtask

   task automatic parse_char(input logic [7:0] ch, input logic st, input logic [7:0] endc);
      logic [63:0]  dig;
      logic [127:0] wide;
      dig = is_digit(ch) ? 64'(ch - CH_ZERO) : 64'd0;
      if (st) begin
         whole_sum      = 64'd0;
         frac_sum       = 20'd0;
         frac_taken     = 0;
         whole_overflow = 1'b0;
         parse_phase    = PH_WHOLE;
      end
      case (parse_phase)
         PH_WHOLE: begin
            if (is_digit(ch)) begin
               wide = {64'd0, whole_sum} * 128'd10 + {64'd0, dig};
               if (wide[127:64] != 64'd0) whole_overflow = 1'b1;
               whole_sum = wide[63:0];
            end else if (ch == CH_DOT) begin
               parse_phase = PH_FRAC;
            end else begin
               close_number(ch, endc);
            end
         end
         PH_FRAC: begin
            if (is_digit(ch)) begin
               // digits past the last fraction position are dropped
               if (frac_taken < FRACTION_DIGITS) begin
                  frac_sum = frac_sum + 20'(dig * ten_to(FRACTION_DIGITS - 1 - frac_taken));
                  frac_taken++;
               end
            end else begin
               close_number(ch, endc);
            end
         end
         default: parse_phase = PH_IDLE;
      endcase
   endtask

   task automatic push_char(input logic [7:0] ch, input logic st, input logic [7:0] endc);
      text_char_type t;
      t.char_code = ch;
      t.start_req = st;
      t.end_char  = endc;
      char_queue.push_back(t);
   endtask

   // body then terminator; start mark on the first character
   task automatic push_number(input string body, input logic [7:0] term,
                              input logic [7:0] endc);
      for (int i = 0; i < body.len(); i++) push_char(body[i], i == 0, endc);
      push_char(term, body.len() == 0, endc);
   endtask

   task automatic push_random_number();
      logic [7:0] endc;
      logic [7:0] term;
      int         n_whole;
      int         n_frac;
      bit         has_dot;
      bit         first;
      endc    = rand_other(1'b0);
      n_whole = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 21) : $urandom_range(0, 6);
      n_frac  = $urandom_range(0, 8);
      has_dot = $urandom_range(0, 2) != 0;
      first   = 1'b1;
      for (int i = 0; i < n_whole; i++) begin
         push_char(CH_ZERO + 8'($urandom_range(0, 9)), first,
                   $urandom_range(0, 1) ? endc : 8'($urandom_range(0, 255)));
         first = 1'b0;
      end
      if (has_dot) begin
         push_char(CH_DOT, first, endc);
         first = 1'b0;
         for (int i = 0; i < n_frac; i++)
            push_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0,
                      $urandom_range(0, 1) ? endc : 8'($urandom_range(0, 255)));
      end
      // now and then leave the number open so the next start mark restarts it
      if ($urandom_range(0, 15) != 0) begin
         term = ($urandom_range(0, 3) != 0) ? endc : rand_other(has_dot);
         push_char(term, first, endc);
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   task automatic check_result(input logic [63:0] value, input status_type st);
      parsed_value_type e;
      if (expected_values.size() == 0) begin
         note_mismatch($sformatf("unexpected word value=%0d status=%0d", value, st));
      end else begin
         e = expected_values.pop_front();
         if (value !== e.value_micro || st !== e.status)
            note_mismatch($sformatf("expected value=%0d status=%0d, got value=%0d status=%0d",
                                    e.value_micro, e.status, value, st));
         case (e.status)
            ST_OK:      numbers_ok++;
            ST_BAD_END: numbers_bad_end++;
            default:    numbers_overflow++;
         endcase
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.char_code  = 8'd0;
      req_bus.start_req  = 1'b0;
      req_bus.end_char   = 8'd0;
      rsp_bus.ready      = 1'b0;
      parse_phase        = PH_IDLE;
      whole_sum          = 64'd0;
      frac_sum           = 20'd0;
      frac_taken         = 0;
      whole_overflow     = 1'b0;
      chars_accepted     = 0;
      results_seen       = 0;
      mismatch_count     = 0;
      numbers_ok         = 0;
      numbers_bad_end    = 0;
      numbers_overflow   = 0;
      req_gap            = 0;
      rsp_stall          = 0;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_char(req_bus.char_code, req_bus.start_req, req_bus.end_char);
            char_queue.delete(0);
            chars_accepted++;
            req_gap = draw_wait(chars_accepted);
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (char_queue.size() > 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.char_code <= char_queue[0].char_code;
               req_bus.start_req <= char_queue[0].start_req;
               req_bus.end_char  <= char_queue[0].end_char;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result(rsp_bus.value_micro, rsp_bus.status);
            results_seen++;
            rsp_stall = draw_wait(results_seen);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int base;
      #1;
      // directed words
      push_char("x", 1'b0, "V");                    // idle, no start mark
      push_number("0", "V", "V");
      push_number("", "V", "V");                    // empty number
      push_number("", "W", "V");
      push_number("12.5", "V", "V");
      push_number("3.1415926", "V", "V");           // extra fraction digits dropped
      push_number("7.25", "W", "V");                // wrong terminator
      push_number("1.2", CH_DOT, "V");              // second dot ends, wrong unit
      push_number("1.2", CH_DOT, CH_DOT);           // second dot as the unit
      push_number(".5", "V", "V");
      push_number("123.", "V", "V");
      push_number("18446744073709.551615", "V", "V");
      push_number("18446744073709.551616", "V", "V");
      push_number("99999999999999999999", "V", "V");
      push_number("18446744073709551616.5", "V", "V");
      push_number("9", 8'h00, 8'h00);
      push_number("9", 8'hFF, 8'hFF);
      push_char("5", 1'b1, "V");                    // restart mid-number
      push_char("5", 1'b0, "V");
      push_number("4", "V", "V");

      base = char_queue.size();
      while (char_queue.size() - base < RANDOM_CHARS) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3))
               push_char(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
         end
         push_random_number();
      end

      while (reset) @(posedge clock);
      while (char_queue.size() != 0 || expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d characters accepted, %0d numbers returned", chars_accepted, results_seen);
      $display("status mix: %0d ok, %0d wrong unit, %0d overflow; %0d mismatches",
               numbers_ok, numbers_bad_end, numbers_overflow, mismatch_count);
      if (mismatch_count == 0) begin
         $display("decimal_text_to_micro_units_core_tb passed");
      end else begin
         $display("decimal_text_to_micro_units_core_tb failed");
      end
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("decimal_text_to_micro_units_core_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/dttmu_pkg.sv
design/dttmu_if.sv
design/decimal_text_to_micro_units_core.sv
tb/decimal_text_to_micro_units_core_tb.sv
